// ----- src/rvp_pkg.sv -----
package rvp_pkg;

	localparam int NUM_CLASSES = 55;
	localparam int CLS_W       = 6;
	localparam int WORD_W      = 32;
	localparam int CYC_W       = 16;
	localparam int REQ_W       = 2;
	localparam int OUT_EV_W    = 40;
	localparam int OUT_CS_W    = 48;
	localparam int TOTAL_BITS  = 48;
	localparam int QUEUE_DEPTH = 2;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 144;

	typedef logic [CLS_W-1:0] cls_t;
	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_DECODE = 2'd0;
	localparam req_t REQ_COUNT  = 2'd1;
	localparam req_t REQ_READ   = 2'd2;

	localparam cls_t CLS_INVALID = 6'd54;

	typedef struct packed {
		cls_t             cls;
		logic             count;
		logic [CYC_W-1:0] cyc;
	} item_t;

endpackage

// ----- src/rvp_ram.sv -----
module rvp_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 55
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/rvp_front.sv -----
module rvp_front (
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [rvp_pkg::S_TDATA_W-1:0] s_tdata,
	input  rvp_pkg::req_t             s_tuser,
	input  logic                      q_full,
	output logic                      q_push,
	output rvp_pkg::item_t            q_item
);
	import rvp_pkg::*;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_ZERO = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;
	localparam logic [6:0] F7_MUL  = 7'b0000001;

	localparam logic [2:0] F3_ZERO  = 3'b000;
	localparam logic [2:0] F3_SHR   = 3'b101;
	localparam logic [2:0] F3_SW    = 3'b010;

	localparam cls_t C_LUI    = 6'd0;
	localparam cls_t C_AUIPC  = 6'd1;
	localparam cls_t C_JAL    = 6'd2;
	localparam cls_t C_JALR   = 6'd3;
	localparam cls_t C_SB     = 6'd15;
	localparam cls_t C_SRAI   = 6'd26;
	localparam cls_t C_SUB    = 6'd28;
	localparam cls_t C_SRA    = 6'd34;
	localparam cls_t C_FENCE  = 6'd37;
	localparam cls_t C_ECALL  = 6'd38;
	localparam cls_t C_EBREAK = 6'd39;
	localparam cls_t C_MUL    = 6'd46;

	localparam cls_t BRANCH_MAP [8] = '{6'd4, 6'd5, 6'd54, 6'd54, 6'd6, 6'd7, 6'd8, 6'd9};
	localparam cls_t LOAD_MAP   [8] = '{6'd10, 6'd11, 6'd12, 6'd54, 6'd13, 6'd14, 6'd54, 6'd54};
	localparam cls_t OPIMM_MAP  [8] = '{6'd18, 6'd24, 6'd19, 6'd20, 6'd21, 6'd25, 6'd22, 6'd23};
	localparam cls_t OP_MAP     [8] = '{6'd27, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd35, 6'd36};
	localparam cls_t SYS_MAP    [8] = '{6'd54, 6'd40, 6'd41, 6'd42, 6'd54, 6'd43, 6'd44, 6'd45};

	logic [WORD_W-1:0] word;
	cls_t              sel;
	logic [6:0]        opc;
	logic [2:0]        f3;
	logic [6:0]        f7;
	logic [11:0]       f12;
	cls_t              dec_cls;

	assign word = s_tdata[WORD_W-1:0];
	assign sel  = s_tdata[WORD_W +: CLS_W];
	assign opc  = word[6:0];
	assign f3   = word[14:12];
	assign f7   = word[31:25];
	assign f12  = word[31:20];

	always_comb begin
		unique case (opc)
			OPC_LUI:    dec_cls = C_LUI;
			OPC_AUIPC:  dec_cls = C_AUIPC;
			OPC_JAL:    dec_cls = C_JAL;
			OPC_JALR:   dec_cls = C_JALR;
			OPC_FENCE:  dec_cls = C_FENCE;
			OPC_BRANCH: dec_cls = BRANCH_MAP[f3];
			OPC_LOAD:   dec_cls = LOAD_MAP[f3];
			OPC_STORE:  dec_cls = (f3 <= F3_SW) ? C_SB + cls_t'(f3) : CLS_INVALID;
			OPC_OPIMM: begin
				if (f3 == F3_SHR && f7 != F7_ZERO) dec_cls = C_SRAI;
				else dec_cls = OPIMM_MAP[f3];
			end
			OPC_OP: begin
				if (f7 == F7_ZERO) dec_cls = OP_MAP[f3];
				else if (f7 == F7_ALT) begin
					if (f3 == F3_ZERO) dec_cls = C_SUB;
					else if (f3 == F3_SHR) dec_cls = C_SRA;
					else dec_cls = OP_MAP[f3];
				end else if (f7 == F7_MUL) dec_cls = C_MUL + cls_t'(f3);
				else dec_cls = CLS_INVALID;
			end
			OPC_SYSTEM: begin
				if (f3 == F3_ZERO) begin
					if (f12 == 12'd0) dec_cls = C_ECALL;
					else if (f12 == 12'd1) dec_cls = C_EBREAK;
					else dec_cls = CLS_INVALID;
				end else dec_cls = SYS_MAP[f3];
			end
			default:    dec_cls = CLS_INVALID;
		endcase
	end

	always_comb begin
		q_item.cyc   = s_tdata[WORD_W+CLS_W +: CYC_W];
		q_item.count = (s_tuser == REQ_DECODE) || (s_tuser == REQ_COUNT);
		if (s_tuser == REQ_DECODE) q_item.cls = dec_cls;
		else q_item.cls = (sel > CLS_INVALID) ? CLS_INVALID : sel;
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

// ----- src/rvp_queue.sv -----
module rvp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rvp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output rvp_pkg::item_t pop_item,
	output logic           empty
);
	import rvp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

	item_t                  slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- src/rvp_back.sv -----
module rvp_back #(
	parameter int EVENT_BITS     = 40,
	parameter int CYCLE_SUM_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rvp_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rvp_pkg::M_TDATA_W-1:0] m_tdata
);
	import rvp_pkg::*;

	localparam int ADDR_W = $clog2(NUM_CLASSES);

	typedef enum logic [1:0] {
		B_IDLE,
		B_CALC,
		B_OUT
	} bstate_t;

	bstate_t                 state_q;
	logic [NUM_CLASSES-1:0]  valid_q;
	logic [TOTAL_BITS-1:0]   total_q;

	cls_t                    cls_q;
	logic                    count_q;
	logic [CYC_W-1:0]        cyc_q;

	cls_t                    out_cls_q;
	logic [OUT_EV_W-1:0]     out_ev_q;
	logic [OUT_CS_W-1:0]     out_cs_q;
	logic [TOTAL_BITS-1:0]   out_tot_q;

	logic [EVENT_BITS-1:0]     ev_rdata;
	logic [CYCLE_SUM_BITS-1:0] cs_rdata;
	logic [EVENT_BITS-1:0]     ev_cur;
	logic [EVENT_BITS-1:0]     ev_new;
	logic [CYCLE_SUM_BITS-1:0] cs_cur;
	logic [CYCLE_SUM_BITS:0]   cs_ext;
	logic [CYCLE_SUM_BITS-1:0] cs_new;
	logic [TOTAL_BITS-1:0]     tot_new;
	logic                      ram_we;

	assign q_pop  = (state_q == B_IDLE) && !q_empty;
	assign ram_we = (state_q == B_CALC) && count_q;

	rvp_ram #(.WIDTH(EVENT_BITS), .DEPTH(NUM_CLASSES)) u_event_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(cls_q)),
		.wdata (ev_new),
		.re    (q_pop),
		.raddr (ADDR_W'(q_item.cls)),
		.rdata (ev_rdata)
	);

	rvp_ram #(.WIDTH(CYCLE_SUM_BITS), .DEPTH(NUM_CLASSES)) u_cycle_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(cls_q)),
		.wdata (cs_new),
		.re    (q_pop),
		.raddr (ADDR_W'(q_item.cls)),
		.rdata (cs_rdata)
	);

	// unwritten entries read as zero
	always_comb begin
		ev_cur  = valid_q[cls_q] ? ev_rdata : '0;
		cs_cur  = valid_q[cls_q] ? cs_rdata : '0;
		ev_new  = (count_q && ev_cur != '1) ? ev_cur + EVENT_BITS'(1) : ev_cur;
		cs_ext  = {1'b0, cs_cur} + {1'b0, CYCLE_SUM_BITS'(cyc_q)};
		if (!count_q) cs_new = cs_cur;
		else if (cs_ext[CYCLE_SUM_BITS]) cs_new = '1;
		else cs_new = cs_ext[CYCLE_SUM_BITS-1:0];
		tot_new = (count_q && total_q != '1) ? total_q + TOTAL_BITS'(1) : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			valid_q  <= '0;
			total_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) state_q <= B_CALC;
				end
				B_CALC: begin
					if (count_q) valid_q[cls_q] <= 1'b1;
					total_q  <= tot_new;
					m_tvalid <= 1'b1;
					state_q  <= B_OUT;
				end
				B_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_q   <= q_item.cls;
			count_q <= q_item.count;
			cyc_q   <= q_item.cyc;
		end
		if (state_q == B_CALC) begin
			out_cls_q <= cls_q;
			out_ev_q  <= OUT_EV_W'(ev_new);
			out_cs_q  <= OUT_CS_W'(cs_new);
			out_tot_q <= tot_new;
		end
	end

	assign m_tdata = {2'b00, out_tot_q, out_cs_q, out_ev_q, out_cls_q};

	a_total_only_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_CALC) |=> (total_q == $past(total_q)))
		else $error("running total changed outside the update step");

	a_result_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_cls_q <= CLS_INVALID))
		else $error("result class out of range");

	a_result_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == B_CALC))
		else $error("result raised without an update step");

endmodule

// ----- src/rv32im_instruction_class_profiler.sv -----
// channel   dir  fields
// s_*       in   tuser: req_type[1:0]; tdata: instruction_word, class_select, cycle_count
// m_*       out  tdata: class_index, class_events, class_cycle_sum, total_events
//
// the front classifies an item in its accept cycle and pushes it into a two-entry queue
// the back handles each item in order: counter read, saturating update and write, result
// the result stays in the output register until taken; the queue keeps accepting meanwhile until full
// the back takes a new item only after the last result is taken, set by the read-modify-write of the counter rams
// reset clears all counters at once through per-class valid bits; no clearing pass
module rv32im_instruction_class_profiler #(
	parameter int EVENT_BITS     = 40,
	parameter int CYCLE_SUM_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// instruction_word[31:0], class_select[37:32], cycle_count[53:38], zero pad
	input  logic [rvp_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  rvp_pkg::req_t                 s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// class_index[5:0], class_events[45:6], class_cycle_sum[93:46], total_events[141:94]
	output logic [rvp_pkg::M_TDATA_W-1:0] m_tdata
);
	import rvp_pkg::*;

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	item_t push_item;
	item_t pop_item;

	rvp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	rvp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	rvp_back #(
		.EVENT_BITS     (EVENT_BITS),
		.CYCLE_SUM_BITS (CYCLE_SUM_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- bench/testbench.sv -----
module testbench;
	import rvp_pkg::*;

	localparam req_t REQ_SPARE = 2'd3;

	localparam logic [6:0] OPC_LUI      = 7'h37;
	localparam logic [6:0] OPC_AUIPC    = 7'h17;
	localparam logic [6:0] OPC_JAL      = 7'h6F;
	localparam logic [6:0] OPC_JALR     = 7'h67;
	localparam logic [6:0] OPC_BRANCH   = 7'h63;
	localparam logic [6:0] OPC_LOAD     = 7'h03;
	localparam logic [6:0] OPC_STORE    = 7'h23;
	localparam logic [6:0] OPC_OPIMM    = 7'h13;
	localparam logic [6:0] OPC_OP       = 7'h33;
	localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM   = 7'h73;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 800;

	typedef enum logic [5:0] {
		K_LUI, K_AUIPC, K_JAL, K_JALR, K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
		K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW,
		K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI,
		K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
		K_FENCE, K_ECALL, K_EBREAK, K_CSRRW, K_CSRRS, K_CSRRC, K_CSRRWI, K_CSRRSI, K_CSRRCI,
		K_MUL, K_MULH, K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU, K_BAD
	} iclass_e;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] tot;
		logic [OUT_CS_W-1:0]   cs;
		logic [OUT_EV_W-1:0]   ev;
		cls_t                  cls;
	} tally_t;

	typedef struct {
		req_t                  rq;
		logic [WORD_W-1:0]     word;
		logic [CLS_W-1:0]      sel;
		logic [CYC_W-1:0]      cyc;
		bit                    typed;
		cls_t                  cls;
		logic [OUT_EV_W-1:0]   ev;
		logic [OUT_CS_W-1:0]   cs;
		logic [TOTAL_BITS-1:0] tot;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	req_t                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	// known answer travelling alongside the offered transaction
	bit     offer_typed;
	tally_t offer_fixed;

	int s_idle_pct;
	int r_idle_pct;
	bit hold_request;
	int mismatch_count;
	int quiet_cycles;

	logic [OUT_EV_W-1:0]   class_events [NUM_CLASSES];
	logic [OUT_CS_W-1:0]   class_cycles [NUM_CLASSES];
	logic [TOTAL_BITS-1:0] retired_total;
	tally_t                expected_tallies [$];

	logic [6:0] opc_list [11] = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH,
		OPC_LOAD, OPC_STORE, OPC_OPIMM, OPC_OP, OPC_MISC_MEM, OPC_SYSTEM};

	stim_row_t directed_rows [27] = '{
		'{REQ_READ,   32'h0000_0000, 6'd0,  16'hFFFF, 1'b1, K_LUI,    40'd0, 48'd0,     48'd0},
		'{REQ_READ,   32'h0000_0000, 6'd63, 16'h0000, 1'b1, K_BAD,    40'd0, 48'd0,     48'd0},
		'{REQ_SPARE,  32'h0000_0000, 6'd5,  16'h1234, 1'b1, K_BNE,    40'd0, 48'd0,     48'd0},
		'{REQ_DECODE, 32'h0000_0037, 6'd0,  16'hFFFF, 1'b1, K_LUI,    40'd1, 48'd65535, 48'd1},
		'{REQ_DECODE, 32'hFFFF_FFFF, 6'd63, 16'h0000, 1'b1, K_BAD,    40'd1, 48'd0,     48'd2},
		'{REQ_DECODE, 32'h0000_0000, 6'd0,  16'h0007, 1'b1, K_BAD,    40'd2, 48'd7,     48'd3},
		'{REQ_COUNT,  32'h0000_0000, 6'd63, 16'h0001, 1'b1, K_BAD,    40'd3, 48'd8,     48'd4},
		'{REQ_DECODE, 32'h0000_0073, 6'd0,  16'h0002, 1'b1, K_ECALL,  40'd1, 48'd2,     48'd5},
		'{REQ_DECODE, 32'h0010_0073, 6'd0,  16'h0003, 1'b1, K_EBREAK, 40'd1, 48'd3,     48'd6},
		'{REQ_DECODE, 32'h0020_0073, 6'd0,  16'h0000, 1'b1, K_BAD,    40'd4, 48'd8,     48'd7},
		'{REQ_DECODE, 32'h0200_0033, 6'd0,  16'h000A, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0600_0033, 6'd0,  16'h000B, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h4000_0033, 6'd0,  16'h000C, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h4000_5033, 6'd0,  16'h000D, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h4000_1033, 6'd0,  16'h000E, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h4000_5013, 6'd0,  16'h000F, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0000_5013, 6'd0,  16'h0010, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0200_5013, 6'd0,  16'h0011, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0000_7067, 6'd0,  16'h0012, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'hFFFF_F00F, 6'd0,  16'h0013, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0000_3003, 6'd0,  16'h0014, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0000_3023, 6'd0,  16'h0015, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0000_2063, 6'd0,  16'h0016, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0000_4073, 6'd0,  16'h0017, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_COUNT,  32'h0000_0000, 6'd0,  16'hFFFF, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_DECODE, 32'h0200_7033, 6'd0,  16'h0018, 1'b0, K_LUI, '0, '0, '0},
		'{REQ_READ,   32'h0000_0000, 6'd54, 16'hFFFF, 1'b0, K_LUI, '0, '0, '0}
	};

	rv32im_instruction_class_profiler uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic iclass_e classify_word(input logic [WORD_W-1:0] w);
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [11:0] f12;
		iclass_e     k;
		f3  = w[14:12];
		f7  = w[31:25];
		f12 = w[31:20];
		k   = K_BAD;
		case (w[6:0])
			OPC_LUI:      k = K_LUI;
			OPC_AUIPC:    k = K_AUIPC;
			OPC_JAL:      k = K_JAL;
			OPC_JALR:     k = K_JALR;
			OPC_MISC_MEM: k = K_FENCE;
			OPC_BRANCH: begin
				case (f3)
					3'd0: k = K_BEQ;
					3'd1: k = K_BNE;
					3'd4: k = K_BLT;
					3'd5: k = K_BGE;
					3'd6: k = K_BLTU;
					3'd7: k = K_BGEU;
					default: k = K_BAD;
				endcase
			end
			OPC_LOAD: begin
				case (f3)
					3'd0: k = K_LB;
					3'd1: k = K_LH;
					3'd2: k = K_LW;
					3'd4: k = K_LBU;
					3'd5: k = K_LHU;
					default: k = K_BAD;
				endcase
			end
			OPC_STORE: begin
				case (f3)
					3'd0: k = K_SB;
					3'd1: k = K_SH;
					3'd2: k = K_SW;
					default: k = K_BAD;
				endcase
			end
			OPC_OPIMM: begin
				case (f3)
					3'd0: k = K_ADDI;
					3'd1: k = K_SLLI;
					3'd2: k = K_SLTI;
					3'd3: k = K_SLTIU;
					3'd4: k = K_XORI;
					3'd5: k = (f7 == F7_BASE) ? K_SRLI : K_SRAI;
					3'd6: k = K_ORI;
					default: k = K_ANDI;
				endcase
			end
			OPC_OP: begin
				if (f7 == F7_BASE || f7 == F7_ALT) begin
					case (f3)
						3'd0: k = (f7 == F7_ALT) ? K_SUB : K_ADD;
						3'd1: k = K_SLL;
						3'd2: k = K_SLT;
						3'd3: k = K_SLTU;
						3'd4: k = K_XOR;
						3'd5: k = (f7 == F7_ALT) ? K_SRA : K_SRL;
						3'd6: k = K_OR;
						default: k = K_AND;
					endcase
				end else if (f7 == F7_MULDIV) begin
					k = iclass_e'(K_MUL + f3);
				end
			end
			OPC_SYSTEM: begin
				case (f3)
					3'd0: begin
						if (f12 == 12'd0)
							k = K_ECALL;
						else if (f12 == 12'd1)
							k = K_EBREAK;
					end
					3'd1: k = K_CSRRW;
					3'd2: k = K_CSRRS;
					3'd3: k = K_CSRRC;
					3'd5: k = K_CSRRWI;
					3'd6: k = K_CSRRSI;
					3'd7: k = K_CSRRCI;
					default: k = K_BAD;
				endcase
			end
			default: k = K_BAD;
		endcase
		return k;
	endfunction

	// update the counters for one accepted decode or count transaction and return what should come out
	function automatic tally_t tally_instruction(input req_t rq, input logic [WORD_W-1:0] w,
			input logic [CLS_W-1:0] sel, input logic [CYC_W-1:0] cyc);
		tally_t            t;
		int                c;
		logic [OUT_CS_W:0] sum;
		logic [TOTAL_BITS:0] tsum;
		if (rq == REQ_DECODE)
			c = classify_word(w);
		else
			c = int'((sel > CLS_INVALID) ? CLS_INVALID : sel);
		if (rq == REQ_DECODE || rq == REQ_COUNT) begin
			if (class_events[c] != '1)
				class_events[c] = class_events[c] + OUT_EV_W'(1);
			sum = {1'b0, class_cycles[c]} + (OUT_CS_W+1)'(cyc);
			class_cycles[c] = sum[OUT_CS_W] ? '1 : sum[OUT_CS_W-1:0];
			tsum = {1'b0, retired_total} + (TOTAL_BITS+1)'(1);
			retired_total = tsum[TOTAL_BITS] ? '1 : tsum[TOTAL_BITS-1:0];
		end
		t.cls = cls_t'(c);
		t.ev  = class_events[c];
		t.cs  = class_cycles[c];
		t.tot = retired_total;
		return t;
	endfunction

	task automatic offer(input req_t rq, input logic [WORD_W-1:0] w, input logic [CLS_W-1:0] sel,
			input logic [CYC_W-1:0] cyc, input bit typed, input tally_t fixed);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid    <= 1'b1;
		s_tuser     <= rq;
		s_tdata     <= {2'b00, cyc, sel, w};
		offer_typed <= typed;
		offer_fixed <= fixed;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// scoreboard: results first, then the new transaction, all on pre-edge values
	always @(posedge clk) begin
		tally_t got;
		tally_t want;
		tally_t pred;
		if (m_tvalid && m_tready) begin
			got.cls = m_tdata[5:0];
			got.ev  = m_tdata[45:6];
			got.cs  = m_tdata[93:46];
			got.tot = m_tdata[141:94];
			if (expected_tallies.size() == 0) begin
				$error("unexpected result transaction: class_index %0d", got.cls);
				mismatch_count++;
			end else begin
				want = expected_tallies.pop_front();
				if (got.cls !== want.cls) begin
					$error("class_index: expected %0d, actual %0d", want.cls, got.cls);
					mismatch_count++;
				end
				if (got.ev !== want.ev) begin
					$error("class_events: expected %0d, actual %0d", want.ev, got.ev);
					mismatch_count++;
				end
				if (got.cs !== want.cs) begin
					$error("class_cycle_sum: expected %0d, actual %0d", want.cs, got.cs);
					mismatch_count++;
				end
				if (got.tot !== want.tot) begin
					$error("total_events: expected %0d, actual %0d", want.tot, got.tot);
					mismatch_count++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			pred = tally_instruction(s_tuser, s_tdata[31:0], s_tdata[37:32], s_tdata[53:38]);
			expected_tallies.push_back(offer_typed ? offer_fixed : pred);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sink side, with a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= r_idle_pct);
			end
		end
	end

	initial begin
		req_t             rq;
		logic [WORD_W-1:0] w;
		logic [CLS_W-1:0]  sel;
		logic [CYC_W-1:0]  cyc;
		int               pick;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = REQ_DECODE;
		offer_typed    = 1'b0;
		offer_fixed    = '0;
		s_idle_pct     = 37;
		r_idle_pct     = 87;
		hold_request   = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		retired_total  = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			class_events[i] = '0;
			class_cycles[i] = '0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].rq, directed_rows[i].word, directed_rows[i].sel,
				directed_rows[i].cyc, directed_rows[i].typed,
				'{directed_rows[i].tot, directed_rows[i].cs, directed_rows[i].ev,
				directed_rows[i].cls});

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				s_idle_pct = 87;
				r_idle_pct = 37;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				s_idle_pct   = 0;
				r_idle_pct   = 0;
				hold_request = 1'b1;
			end
			pick = $urandom_range(99);
			w    = $urandom;
			sel  = CLS_W'($urandom_range(63));
			cyc  = CYC_W'($urandom);
			case ($urandom_range(7))
				0: cyc = '0;
				1: cyc = '1;
				default: ;
			endcase
			if (pick < 65) begin
				// known opcodes with random operand fields; funct fields only partly constrained
				rq     = REQ_DECODE;
				w[6:0] = opc_list[$urandom_range(10)];
				case ($urandom_range(3))
					0: w[31:25] = F7_BASE;
					1: w[31:25] = F7_ALT;
					2: w[31:25] = F7_MULDIV;
					default: ;
				endcase
				if (w[6:0] == OPC_SYSTEM && w[14:12] == 3'd0) begin
					case ($urandom_range(2))
						0: w[31:20] = 12'h000;
						1: w[31:20] = 12'h001;
						default: ;
					endcase
				end
			end else if (pick < 75) begin
				rq = REQ_DECODE;
			end else if (pick < 88) begin
				rq = REQ_COUNT;
			end else begin
				rq = $urandom_range(1) ? REQ_READ : REQ_SPARE;
			end
			offer(rq, w, sel, cyc, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
